>>> rtl/core/ryc_pkg.sv
package ryc_pkg;

  localparam int MAX_WIDTH    = 4096;
  localparam int MAX_HEIGHT   = 4096;
  localparam int STRIDE_ALIGN = 16;

  localparam int CFG_W    = 13;
  localparam int CFG_IDX_W = 2;
  localparam int MODE_W   = 2;
  localparam int WDIM_W   = $clog2(MAX_WIDTH + 1);
  localparam int HDIM_W   = $clog2(MAX_HEIGHT + 1);
  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int ROW_W    = $clog2(MAX_HEIGHT);
  localparam int STRIDE_W = $clog2(MAX_WIDTH + STRIDE_ALIGN);
  localparam int PIX_W    = 8;
  localparam int ADDR_W   = 24;
  localparam int SUM_W    = 26;
  localparam int FRAC_W   = 16;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
  localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

  localparam int Y_R  = 19595;
  localparam int Y_G  = 38470;
  localparam int Y_B  = 7471;
  localparam int C_OFS = 8355840;
  localparam int CB_R = 11058;
  localparam int CB_G = 21710;
  localparam int CB_B = 32768;
  localparam int CR_R = 32768;
  localparam int CR_G = 27439;
  localparam int CR_B = 5329;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH,
    REG_IMAGE_HEIGHT,
    REG_CHROMA_MODE
  } cfg_reg_t;

  typedef enum logic [MODE_W-1:0] {
    CM_420,
    CM_422,
    CM_444
  } chroma_mode_t;

  typedef struct packed {
    logic [WDIM_W-1:0]   width;
    logic [HDIM_W-1:0]   height;
    logic [STRIDE_W-1:0] stride;
    logic [MODE_W-1:0]   mode;
  } cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0]    red;
    logic [PIX_W-1:0]    green;
    logic [PIX_W-1:0]    blue;
    logic [COL_W-1:0]    col;
    logic [ROW_W-1:0]    row;
    logic [STRIDE_W-1:0] stride;
    logic [MODE_W-1:0]   mode;
    logic                frame_end;
  } s1_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] y_sum;
    logic signed [SUM_W-1:0] cb_sum;
    logic signed [SUM_W-1:0] cr_sum;
    logic [COL_W-1:0]        col;
    logic                    row_odd;
    logic [MODE_W-1:0]       mode;
    logic [ADDR_W-1:0]       luma_prod;
    logic [ADDR_W-1:0]       chroma_prod;
    logic                    frame_end;
  } s2_t;

  typedef struct packed {
    logic [PIX_W-1:0]  luma;
    logic [ADDR_W-1:0] luma_addr;
    logic              chroma_valid;
    logic [PIX_W-1:0]  cb;
    logic [PIX_W-1:0]  cr;
    logic [ADDR_W-1:0] chroma_addr;
    logic              frame_end;
  } out_t;

  function automatic logic [PIX_W-1:0] clamp_q16(logic signed [SUM_W-1:0] q);
    logic [SUM_W-FRAC_W-1:0] whole;
    whole = q[SUM_W-1:FRAC_W];
    if (q < 0) begin
      return '0;
    end else if (whole > (SUM_W-FRAC_W)'(255)) begin
      return '1;
    end else begin
      return q[FRAC_W+PIX_W-1:FRAC_W];
    end
  endfunction

endpackage

>>> rtl/core/ryc_if.sv
interface ryc_pix_if;
  logic                      valid;
  logic                      ready;
  logic [ryc_pkg::PIX_W-1:0] red;
  logic [ryc_pkg::PIX_W-1:0] green;
  logic [ryc_pkg::PIX_W-1:0] blue;

  modport source(output valid, output red, output green, output blue, input ready);
  modport sink(input valid, input red, input green, input blue, output ready);
endinterface

interface ryc_ycc_if;
  logic                       valid;
  logic                       ready;
  logic [ryc_pkg::PIX_W-1:0]  luma;
  logic [ryc_pkg::ADDR_W-1:0] luma_addr;
  logic                       chroma_valid;
  logic [ryc_pkg::PIX_W-1:0]  cb;
  logic [ryc_pkg::PIX_W-1:0]  cr;
  logic [ryc_pkg::ADDR_W-1:0] chroma_addr;
  logic                       frame_end;

  modport source(output valid, output luma, output luma_addr, output chroma_valid,
                 output cb, output cr, output chroma_addr, output frame_end,
                 input ready);
  modport sink(input valid, input luma, input luma_addr, input chroma_valid,
               input cb, input cr, input chroma_addr, input frame_end,
               output ready);
endinterface

>>> rtl/core/ryc_cfg.sv
module ryc_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [ryc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ryc_pkg::CFG_W-1:0]         cfg_data,
  output ryc_pkg::cfg_t                     cfg
);

  logic [ryc_pkg::CFG_W-1:0]  width_reg;
  logic [ryc_pkg::CFG_W-1:0]  height_reg;
  logic [ryc_pkg::MODE_W-1:0] mode_reg;
  logic [ryc_pkg::WDIM_W-1:0] width_eff;
  logic [ryc_pkg::STRIDE_W-1:0] stride_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= ryc_pkg::WIDTH_RESET;
      height_reg <= ryc_pkg::HEIGHT_RESET;
      mode_reg   <= ryc_pkg::CM_420;
    end else if (cfg_we) begin
      case (cfg_index)
        ryc_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
        ryc_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_data;
        ryc_pkg::REG_CHROMA_MODE:  mode_reg   <= cfg_data[ryc_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_reg == '0) begin
      width_eff = ryc_pkg::WDIM_W'(1);
    end else if (32'(width_reg) > ryc_pkg::MAX_WIDTH) begin
      width_eff = ryc_pkg::WDIM_W'(ryc_pkg::MAX_WIDTH);
    end else begin
      width_eff = ryc_pkg::WDIM_W'(width_reg);
    end

    if (height_reg == '0) begin
      cfg.height = ryc_pkg::HDIM_W'(1);
    end else if (32'(height_reg) > ryc_pkg::MAX_HEIGHT) begin
      cfg.height = ryc_pkg::HDIM_W'(ryc_pkg::MAX_HEIGHT);
    end else begin
      cfg.height = ryc_pkg::HDIM_W'(height_reg);
    end

    stride_sum = ryc_pkg::STRIDE_W'(width_eff)
               + ryc_pkg::STRIDE_W'(ryc_pkg::STRIDE_ALIGN - 1);
    cfg.width  = width_eff;
    cfg.stride = stride_sum & ~ryc_pkg::STRIDE_W'(ryc_pkg::STRIDE_ALIGN - 1);
    cfg.mode   = mode_reg;
  end

endmodule

>>> rtl/core/ryc_raster.sv
module ryc_raster (
  input  logic          clk,
  input  logic          rst,
  input  ryc_pkg::cfg_t cfg,
  ryc_pix_if.sink       pix_in,
  output logic          s1_valid,
  input  logic          s1_ready,
  output ryc_pkg::s1_t  s1
);

  logic [ryc_pkg::COL_W-1:0] col;
  logic [ryc_pkg::ROW_W-1:0] row;
  logic [ryc_pkg::COL_W-1:0] col_next;
  logic [ryc_pkg::ROW_W-1:0] row_next;
  logic                      accept;
  logic                      last_col;
  logic                      last_row;
  logic                      frame_last;

  assign pix_in.ready = !s1_valid || s1_ready;
  assign accept       = pix_in.valid && pix_in.ready;

  always_comb begin
    last_col   = (ryc_pkg::WDIM_W'(col) + ryc_pkg::WDIM_W'(1)) >= cfg.width;
    last_row   = (ryc_pkg::HDIM_W'(row) + ryc_pkg::HDIM_W'(1)) >= cfg.height;
    frame_last = last_col && last_row;
    col_next   = col;
    row_next   = row;
    if (accept) begin
      if (last_col) begin
        col_next = '0;
        row_next = last_row ? '0 : row + ryc_pkg::ROW_W'(1);
      end else begin
        col_next = col + ryc_pkg::COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      s1_valid <= 1'b0;
    end else begin
      col <= col_next;
      row <= row_next;
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_ready) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1.red       <= pix_in.red;
      s1.green     <= pix_in.green;
      s1.blue      <= pix_in.blue;
      s1.col       <= col;
      s1.row       <= row;
      s1.stride    <= cfg.stride;
      s1.mode      <= cfg.mode;
      s1.frame_end <= frame_last;
    end
  end

  a_frame_wraps: assert property (@(posedge clk) disable iff (rst)
    accept && frame_last |=> col == '0 && row == '0)
    else $error("Counters did not return to the origin after the last pixel.");

  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_ready |=> s1_valid && $stable(s1))
    else $error("Input stage changed while stalled.");

endmodule

>>> rtl/core/ryc_convert.sv
module ryc_convert (
  input  logic         clk,
  input  logic         rst,
  input  logic         s1_valid,
  output logic         s1_ready,
  input  ryc_pkg::s1_t s1,
  ryc_ycc_if.source    ycc_out
);

  logic          s2_valid;
  logic          s2_ready;
  ryc_pkg::s2_t  s2;
  ryc_pkg::s2_t  s2_next;
  logic          out_valid;
  ryc_pkg::out_t out_reg;
  ryc_pkg::out_t out_next;
  logic [ryc_pkg::ROW_W-1:0]    crow;
  logic [ryc_pkg::STRIDE_W-1:0] cstride;
  logic [ryc_pkg::COL_W-1:0]    chalf;

  assign s2_ready = !out_valid || ycc_out.ready;
  assign s1_ready = !s2_valid || s2_ready;

  always_comb begin
    crow    = (s1.mode == ryc_pkg::CM_420) ? (s1.row >> 1) : s1.row;
    cstride = (s1.mode == ryc_pkg::CM_444) ? s1.stride : (s1.stride >> 1);

    s2_next.y_sum  = ryc_pkg::SUM_W'(ryc_pkg::Y_R * int'(s1.red)
                   + ryc_pkg::Y_G * int'(s1.green) + ryc_pkg::Y_B * int'(s1.blue));
    s2_next.cb_sum = ryc_pkg::SUM_W'(ryc_pkg::C_OFS - ryc_pkg::CB_R * int'(s1.red)
                   - ryc_pkg::CB_G * int'(s1.green) + ryc_pkg::CB_B * int'(s1.blue));
    s2_next.cr_sum = ryc_pkg::SUM_W'(ryc_pkg::C_OFS + ryc_pkg::CR_R * int'(s1.red)
                   - ryc_pkg::CR_G * int'(s1.green) - ryc_pkg::CR_B * int'(s1.blue));
    s2_next.col         = s1.col;
    s2_next.row_odd     = s1.row[0];
    s2_next.mode        = s1.mode;
    s2_next.luma_prod   = ryc_pkg::ADDR_W'(s1.row) * ryc_pkg::ADDR_W'(s1.stride);
    s2_next.chroma_prod = ryc_pkg::ADDR_W'(crow) * ryc_pkg::ADDR_W'(cstride);
    s2_next.frame_end   = s1.frame_end;
  end

  always_comb begin
    chalf = s2.col >> 1;
    out_next.luma      = ryc_pkg::clamp_q16(s2.y_sum);
    out_next.luma_addr = ryc_pkg::ADDR_W'(s2.col) + s2.luma_prod;
    out_next.frame_end = s2.frame_end;
    case (s2.mode)
      ryc_pkg::CM_444: begin
        out_next.chroma_valid = 1'b1;
        out_next.chroma_addr  = ryc_pkg::ADDR_W'(s2.col) + s2.chroma_prod;
      end
      ryc_pkg::CM_420: begin
        out_next.chroma_valid = !s2.col[0] && !s2.row_odd;
        out_next.chroma_addr  = ryc_pkg::ADDR_W'(chalf) + s2.chroma_prod;
      end
      ryc_pkg::CM_422: begin
        out_next.chroma_valid = !s2.col[0];
        out_next.chroma_addr  = ryc_pkg::ADDR_W'(chalf) + s2.chroma_prod;
      end
      default: begin
        out_next.chroma_valid = !s2.col[0];
        out_next.chroma_addr  = ryc_pkg::ADDR_W'(chalf) + s2.chroma_prod;
      end
    endcase
    if (out_next.chroma_valid) begin
      out_next.cb = ryc_pkg::clamp_q16(s2.cb_sum);
      out_next.cr = ryc_pkg::clamp_q16(s2.cr_sum);
    end else begin
      out_next.cb          = '0;
      out_next.cr          = '0;
      out_next.chroma_addr = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s2_valid <= s1_valid;
      end
      if (s2_ready) begin
        out_valid <= s2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_ready) begin
      s2 <= s2_next;
    end
    if (s2_valid && s2_ready) begin
      out_reg <= out_next;
    end
  end

  assign ycc_out.valid        = out_valid;
  assign ycc_out.luma         = out_reg.luma;
  assign ycc_out.luma_addr    = out_reg.luma_addr;
  assign ycc_out.chroma_valid = out_reg.chroma_valid;
  assign ycc_out.cb           = out_reg.cb;
  assign ycc_out.cr           = out_reg.cr;
  assign ycc_out.chroma_addr  = out_reg.chroma_addr;
  assign ycc_out.frame_end    = out_reg.frame_end;

  a_s2_holds: assert property (@(posedge clk) disable iff (rst)
    s2_valid && !s2_ready |=> s2_valid && $stable(s2))
    else $error("Product stage changed while stalled.");

  a_no_chroma_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_reg.chroma_valid |->
      out_reg.cb == '0 && out_reg.cr == '0 && out_reg.chroma_addr == '0)
    else $error("Dropped chroma carries nonzero fields.");

endmodule

>>> rtl/core/rgb_to_ycbcr_planar_subsampler.sv
// Converts a raster stream of RGB pixels to full-range BT.601 Y, Cb and Cr bytes
// with their byte addresses in planar luma and chroma buffers.
// The pixel channel pix_in carries red, green and blue; a transaction happens
// at a rising edge where valid and ready are both high. Each accepted pixel
// yields exactly one transaction on ycc_out with luma, luma_addr, chroma_valid,
// cb, cr, chroma_addr and frame_end.
// The configuration port writes image_width, image_height or chroma_mode when
// cfg_we is high; write it only while no pixel is in flight.
// The datapath has three register stages: input, products and result. An
// accepted pixel moves through them in that order, and one pixel per cycle
// is sustained while ycc_out.ready stays high; the rate is set by the single
// pass through the coefficient and address multipliers.
// Reset clears the column and row counters, empties the pipeline and restores
// a 640 by 480 image in 4:2:0 mode.
// When the receiver stalls, the result is held and each stage keeps taking
// data until it is full; the input is stalled once all three stages hold a pixel.
module rgb_to_ycbcr_planar_subsampler (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [ryc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ryc_pkg::CFG_W-1:0]     cfg_data,
  ryc_pix_if.sink                       pix_in,
  ryc_ycc_if.source                     ycc_out
);

  ryc_pkg::cfg_t cfg;
  logic          s1_valid;
  logic          s1_ready;
  ryc_pkg::s1_t  s1;

  ryc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ryc_raster u_raster (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .pix_in   (pix_in),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s1       (s1)
  );

  ryc_convert u_convert (
    .clk      (clk),
    .rst      (rst),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s1       (s1),
    .ycc_out  (ycc_out)
  );

endmodule
